### hw/rtl/bti_pkg.sv
// Shared types, constants and helpers for the bilinear table interpolator.
// No dependencies.
package bti_pkg;

   localparam int unsigned MaxPoints  = 256;
   localparam int unsigned IdxW       = 8;
   localparam int unsigned CntW       = 9;
   localparam int unsigned CoarseSegs = 50;
   localparam int unsigned SegW       = 6;
   localparam int unsigned QDepth     = 2;

   // (n - 1) / CoarseSegs as ((n - 1) * SegRecip) >> SegShift, exact for n - 1 below 256
   localparam int unsigned SegRecip   = 41;
   localparam int unsigned SegShift   = 11;

   localparam logic [1:0] KIND_LOAD_DENS = 2'd0;
   localparam logic [1:0] KIND_LOAD_TEMP = 2'd1;
   localparam logic [1:0] KIND_LOAD_GRID = 2'd2;
   localparam logic [1:0] KIND_QUERY     = 2'd3;

   localparam logic CSR_DENS_POINTS = 1'b0;
   localparam logic CSR_TEMP_POINTS = 1'b1;

   // request payload
   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         row_index;
      logic [7:0]         col_index;
      logic signed [63:0] load_value;
      logic signed [63:0] query_density;
      logic signed [63:0] query_temperature;
   } req_type;

   // response payload
   typedef struct packed {
      logic signed [63:0] interpolated;
      logic               status;
      logic [7:0]         density_cell;
      logic [7:0]         temperature_cell;
   } rsp_type;

   // clamp a point count into [2, MaxPoints]
   function automatic logic [CntW-1:0] clamp_points(input logic [CntW-1:0] v);
      logic [CntW-1:0] r;
      r = v;
      if (v < CntW'(2)) r = CntW'(2);
      else if (v > CntW'(MaxPoints)) r = CntW'(MaxPoints);
      return r;
   endfunction

endpackage

### hw/rtl/bti_if.sv
// Valid/ready channel carrying one payload type.
// Depends on bti_pkg for the payload types.
interface bti_req_if;
   logic             valid;
   logic             ready;
   bti_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bti_rsp_if;
   logic             valid;
   logic             ready;
   bti_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/bti_front.sv
// Front end: accepts requests and queues all of them in a two-entry queue.
// Depends on bti_pkg and bti_if.
module bti_front (
   input  logic             clock,
   input  logic             reset,
   bti_req_if.sink          req,
   output logic             q_valid,
   output bti_pkg::req_type q_data,
   input  logic             q_pop
);
   bti_pkg::req_type    mem_ff [bti_pkg::QDepth];
   logic                wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                push;

   assign req.ready = (cnt_ff != 2'(bti_pkg::QDepth));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rd_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_in  = wr_ff + 1'(push);
      rd_in  = rd_ff + 1'(q_pop);
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= req.data;
   end
endmodule

### hw/rtl/bti_divider.sv
// Restoring divider: floor(num * 2^32 / den), one quotient bit a cycle.
// A zero den or num >= den gives 0. Depends on nothing but its ports.
module bti_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [31:0] quo
);
   logic [63:0] rem_ff, rem_in, den_ff;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] sh;

   assign done = done_ff;
   assign quo  = quo_ff;
   assign sh   = {rem_ff, 1'b0};

   // one shift-subtract step a cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = !(den == 64'd0 || num >= den);
         done_in = !busy_in;
      end else if (busy_ff) begin
         if (sh >= {1'b0, den_ff}) begin
            rem_in = 64'(sh - {1'b0, den_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = sh[63:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) den_ff <= den;
   end
endmodule

### hw/rtl/bti_back.sv
// Back end: table stores, range check, axis search, fractions and blending.
// Depends on bti_pkg, bti_if and bti_divider.
module bti_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  bti_pkg::req_type q_data,
   output logic             q_pop,
   input  logic [8:0]       dens_points,
   input  logic [8:0]       temp_points,
   bti_rsp_if.source        rsp
);
   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_RNG0   = 13'b0000000000010,
      S_RNG1   = 13'b0000000000100,
      S_COARSE = 13'b0000000001000,
      S_FINE   = 13'b0000000010000,
      S_CELL   = 13'b0000000100000,
      S_FRAC   = 13'b0000001000000,
      S_DIVW   = 13'b0000010000000,
      S_GRID   = 13'b0000100000000,
      S_GRIDW  = 13'b0001000000000,
      S_MUL    = 13'b0010000000000,
      S_SUM    = 13'b0100000000000,
      S_OUT    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // stores
   logic [63:0] dens_mem [bti_pkg::MaxPoints];
   logic [63:0] temp_mem [bti_pkg::MaxPoints];
   logic [63:0] grid_mem [bti_pkg::MaxPoints * bti_pkg::MaxPoints];
   logic [7:0]  d_addr, t_addr;
   logic [15:0] g_addr;
   logic [63:0] d_rd_ff, t_rd_ff, g_rd_ff;

   logic [8:0]  nd_ff, nt_ff, stride_d_ff, stride_t_ff;
   logic [15:0] sd_prod, st_prod;
   logic [8:0]  k_ff, k_in;
   logic [5:0]  seg_ff, seg_in;
   logic        axis_ff, axis_in;          // 0 density, 1 temperature
   logic [1:0]  sub_ff, sub_in;            // read phase / product half
   logic        out_ff, out_in;
   logic [7:0]  ci_ff, ci_in, cj_ff, cj_in;
   logic [63:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [31:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [63:0] c_ff [4];
   logic [1:0]  gsel_ff, gsel_in;
   logic [2:0]  mstep_ff, mstep_in;
   logic signed [127:0] acc_ff, acc_in;
   logic [63:0] l0_ff, l0_in, l1_ff, l1_in;
   logic signed [66:0] prod_ff;
   logic [63:0]        m_src;
   logic signed [32:0] m_part;
   logic [32:0]        m_w;
   logic        div_start;
   logic [63:0] div_num, div_den, q_sel;
   logic        div_done;
   logic [31:0] div_quo;
   logic        rsp_valid_ff, rsp_valid_in;
   bti_pkg::rsp_type rsp_ff, rsp_in, res_ff, res_in;
   logic        is_load, q_lt_rd;
   logic [63:0] rd_axis;
   logic [8:0]  n_cur, stride_cur, cidx;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;
   assign is_load   = (state_ff == S_IDLE) && q_valid && (q_data.kind != bti_pkg::KIND_QUERY);
   assign rd_axis   = axis_ff ? t_rd_ff : d_rd_ff;
   assign q_sel     = axis_ff ? q_data.query_temperature : q_data.query_density;
   assign q_lt_rd   = $signed(q_sel) < $signed(rd_axis);
   assign n_cur     = axis_ff ? nt_ff : nd_ff;
   assign stride_cur = axis_ff ? stride_t_ff : stride_d_ff;

   // coarse strides by reciprocal multiplication
   assign sd_prod = 16'(nd_ff - 9'd1) * 16'(bti_pkg::SegRecip);
   assign st_prod = 16'(nt_ff - 9'd1) * 16'(bti_pkg::SegRecip);

   // stores: one write port, registered read
   always_ff @(posedge clock) begin
      if (is_load && q_data.kind == bti_pkg::KIND_LOAD_DENS)
         dens_mem[q_data.row_index] <= q_data.load_value;
      if (is_load && q_data.kind == bti_pkg::KIND_LOAD_TEMP)
         temp_mem[q_data.row_index] <= q_data.load_value;
      if (is_load && q_data.kind == bti_pkg::KIND_LOAD_GRID)
         grid_mem[{q_data.row_index, q_data.col_index}] <= q_data.load_value;
      d_rd_ff <= dens_mem[d_addr];
      t_rd_ff <= temp_mem[t_addr];
      g_rd_ff <= grid_mem[g_addr];
   end

   // read addresses: axes from k, grid from the cell and corner select
   always_comb begin
      cidx   = k_ff;
      d_addr = cidx[7:0];
      t_addr = cidx[7:0];
      g_addr = {cj_ff + 8'(gsel_ff[1]), ci_ff + 8'(gsel_ff[0])};
   end

   bti_divider u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (div_den), .done (div_done), .quo (div_quo)
   );

   // operand and weight per product; each product is taken as two 32-bit halves
   always_comb begin
      unique case (mstep_ff)
         3'd0: begin m_src = c_ff[0]; m_w = 33'h100000000 - 33'(fx_ff); end
         3'd1: begin m_src = c_ff[1]; m_w = 33'(fx_ff); end
         3'd2: begin m_src = c_ff[2]; m_w = 33'h100000000 - 33'(fx_ff); end
         3'd3: begin m_src = c_ff[3]; m_w = 33'(fx_ff); end
         3'd4: begin m_src = l0_ff; m_w = 33'h100000000 - 33'(fy_ff); end
         default: begin m_src = l1_ff; m_w = 33'(fy_ff); end
      endcase
      m_part = sub_ff[0] ? $signed({m_src[63], m_src[63:32]})
                         : $signed({1'b0, m_src[31:0]});
   end

   always_ff @(posedge clock) begin
      prod_ff <= 67'(m_part) * 67'($signed({1'b0, m_w}));
      if (state_ff == S_GRIDW) c_ff[gsel_ff] <= g_rd_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in = k_ff; seg_in = seg_ff; axis_in = axis_ff; sub_in = sub_ff;
      out_in = out_ff; ci_in = ci_ff; cj_in = cj_ff; lo_in = lo_ff; hi_in = hi_ff;
      fx_in = fx_ff; fy_in = fy_ff; gsel_in = gsel_ff; mstep_in = mstep_ff;
      acc_in = acc_ff; l0_in = l0_ff; l1_in = l1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in = rsp_ff;
      res_in = res_ff;
      q_pop = 1'b0; div_start = 1'b0;
      div_num = lo_ff; div_den = hi_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (is_load) q_pop = 1'b1;
            else if (q_valid) begin
               axis_in = 1'b0; out_in = 1'b0; sub_in = 2'd0; k_in = 9'd0;
               state_in = S_RNG0;
            end
         end
         // check first and last entry of each axis
         S_RNG0: begin
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd0) k_in = n_cur - 9'd1;
            if (sub_ff == 2'd1) begin
               if (q_lt_rd) out_in = 1'b1;
            end
            if (sub_ff == 2'd2) begin
               if (!q_lt_rd) out_in = 1'b1;
               sub_in = 2'd0;
               k_in = 9'd0;
               if (axis_ff) state_in = S_RNG1;
               axis_in = !axis_ff;
            end
         end
         S_RNG1: begin
            if (out_ff) begin
               res_in = '{interpolated: 64'sd0, status: 1'b1,
                          density_cell: 8'd0, temperature_cell: 8'd0};
               state_in = S_OUT;
            end else begin
               axis_in = 1'b0; seg_in = 6'd1; k_in = stride_d_ff; sub_in = 2'd0;
               state_in = S_COARSE;
            end
         end
         // coarse strides: address k, data arrives in the next cycle
         S_COARSE: begin
            if (sub_ff == 2'd0) sub_in = 2'd1;
            else begin
               sub_in = 2'd0;
               if (q_lt_rd) begin
                  k_in = k_ff - stride_cur;
                  state_in = S_FINE;
               end else if (seg_ff == 6'(bti_pkg::CoarseSegs)) begin
                  k_in = 9'd0;
                  state_in = S_FINE;
               end else begin
                  seg_in = seg_ff + 6'd1;
                  k_in = k_ff + stride_cur;
               end
            end
         end
         S_FINE: begin
            if (sub_ff == 2'd0) sub_in = 2'd1;
            else begin
               sub_in = 2'd0;
               if (q_lt_rd || k_ff == n_cur - 9'd1) begin
                  if (axis_ff) cj_in = (k_ff == 9'd0) ? 8'd0 : 8'(k_ff - 9'd1);
                  else         ci_in = (k_ff == 9'd0) ? 8'd0 : 8'(k_ff - 9'd1);
                  k_in = (k_ff == 9'd0) ? 9'd0 : k_ff - 9'd1;
                  state_in = S_CELL;
               end else k_in = k_ff + 9'd1;
            end
         end
         // fetch a[i] and a[i+1]
         S_CELL: begin
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd0) k_in = k_ff + 9'd1;
            if (sub_ff == 2'd1) lo_in = rd_axis;
            if (sub_ff == 2'd2) begin
               hi_in = rd_axis - lo_ff;
               lo_in = q_sel - lo_ff;
               sub_in = 2'd0;
               state_in = S_FRAC;
            end
         end
         S_FRAC: begin
            div_start = 1'b1;
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               if (axis_ff) begin
                  fy_in = div_quo;
                  gsel_in = 2'd0;
                  state_in = S_GRID;
               end else begin
                  fx_in = div_quo;
                  axis_in = 1'b1; seg_in = 6'd1; k_in = stride_t_ff;
                  state_in = S_COARSE;
               end
            end
         end
         // four corner reads
         S_GRID: state_in = S_GRIDW;
         S_GRIDW: begin
            gsel_in = gsel_ff + 2'd1;
            if (gsel_ff == 2'd3) begin
               mstep_in = 3'd0; sub_in = 2'd0;
               state_in = S_MUL;
            end else state_in = S_GRID;
         end
         // six products, each low half then high half, summed in pairs
         S_MUL: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            if (sub_ff == 2'd0) begin
               if (mstep_ff[0] == 1'b0) acc_in = 128'sh80000000 + 128'(prod_ff);
               else acc_in = acc_ff + 128'(prod_ff);
               sub_in = 2'd1;
               state_in = S_MUL;
            end else begin
               acc_in = acc_ff + (128'(prod_ff) <<< 32);
               sub_in = 2'd0;
               if (mstep_ff[0] == 1'b1) begin
                  unique case (mstep_ff[2:1])
                     2'd0: l0_in = acc_in[95:32];
                     2'd1: l1_in = acc_in[95:32];
                     default: begin
                        res_in = '{interpolated: acc_in[95:32], status: 1'b0,
                                   density_cell: ci_ff, temperature_cell: cj_ff};
                     end
                  endcase
               end
               mstep_in = mstep_ff + 3'd1;
               state_in = (mstep_ff == 3'd5) ? S_OUT : S_MUL;
            end
         end
         // result register loaded only once the previous response has gone
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = res_ff;
               q_pop = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; seg_ff <= seg_in; axis_ff <= axis_in; sub_ff <= sub_in;
      out_ff <= out_in; ci_ff <= ci_in; cj_ff <= cj_in; lo_ff <= lo_in; hi_ff <= hi_in;
      fx_ff <= fx_in; fy_ff <= fy_in; gsel_ff <= gsel_in; mstep_ff <= mstep_in;
      acc_ff <= acc_in; l0_ff <= l0_in; l1_ff <= l1_in; rsp_ff <= rsp_in;
      res_ff <= res_in;
      // point counts and coarse strides latched per query
      if (state_ff == S_IDLE) begin
         nd_ff <= bti_pkg::clamp_points(dens_points);
         nt_ff <= bti_pkg::clamp_points(temp_points);
      end
      stride_d_ff <= 9'(sd_prod >> bti_pkg::SegShift);
      stride_t_ff <= 9'(st_prod >> bti_pkg::SegShift);
   end
endmodule

### hw/rtl/bilinear_table_interpolator_unit.sv
// Bilinear interpolator over a non-uniform grid: top level.
// A load is written when the back end pops it from the queue; a query walks each axis,
// runs two divisions for the fractions, then blends the four corners before answering.
// Throughput: one query at a time; loads one a cycle through the two-entry queue while no query is in progress.
// Reset: synchronous, active high; clears control and sets both point counts to 256;
// tables are not cleared and must be loaded before use.
module bilinear_table_interpolator_unit (
   input  logic        clock,
   input  logic        reset,
   bti_req_if.sink     req,
   bti_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [8:0]  csr_write_data
);
   logic [8:0]       dens_pts_ff, temp_pts_ff;
   logic             q_valid, q_pop;
   bti_pkg::req_type q_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dens_pts_ff <= 9'd256;
         temp_pts_ff <= 9'd256;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bti_pkg::CSR_DENS_POINTS: dens_pts_ff <= csr_write_data;
            default:                  temp_pts_ff <= csr_write_data;
         endcase
      end
   end

   bti_front u_front (
      .clock (clock), .reset (reset), .req (req),
      .q_valid (q_valid), .q_data (q_data), .q_pop (q_pop)
   );

   bti_back u_back (
      .clock (clock), .reset (reset),
      .q_valid (q_valid), .q_data (q_data), .q_pop (q_pop),
      .dens_points (dens_pts_ff), .temp_points (temp_pts_ff), .rsp (rsp)
   );

`ifndef SYNTHESIS
   // a pop only happens when the queue holds something
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   // a held response keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response changed while stalled");
   // out-of-range results carry zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.status |-> rsp.data.interpolated == 64'sd0)
      else $error("out-of-range result not zero");
`endif
endmodule
